// ===== rtl/tdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Time delta parser package
// Shared character codes, parse state codes and the classified byte record
// that the front end hands to the execute stage through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tdp_pkg;

  // Character codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_Y     = 8'h79;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_S     = 8'h73;

  // Number form codes
  localparam logic [2:0] FORM_NONE  = 3'd0;
  localparam logic [2:0] FORM_MINUS = 3'd1;
  localparam logic [2:0] FORM_PLUS  = 3'd2;
  localparam logic [2:0] FORM_NEG   = 3'd3;
  localparam logic [2:0] FORM_POS   = 3'd4;
  localparam logic [2:0] FORM_BAD   = 3'd5;

  // Suffix codes; slot of a unit is its code minus one
  localparam logic [3:0] SUF_EMPTY  = 4'd0;
  localparam logic [3:0] SUF_YEAR   = 4'd1;
  localparam logic [3:0] SUF_M      = 4'd2;
  localparam logic [3:0] SUF_DAY    = 4'd3;
  localparam logic [3:0] SUF_HOUR   = 4'd4;
  localparam logic [3:0] SUF_MN     = 4'd5;
  localparam logic [3:0] SUF_SECOND = 4'd6;
  localparam logic [3:0] SUF_BAD    = 4'd7;

  localparam int          UNIT_COUNT = 6;
  localparam logic [15:0] MAG_CAP    = 16'd32769;
  localparam logic [15:0] NEG_LIMIT  = 16'd32768;
  localparam logic [15:0] POS_LIMIT  = 16'd32767;

  // Queue between front end and execute stage
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Classified text byte
  typedef struct packed {
    logic       is_num;     // sign or digit
    logic       is_sign;
    logic       minus;
    logic [3:0] digit;
    logic [3:0] suf_first;  // suffix code if it opens a suffix
    logic       is_n;       // second letter of the minute suffix
    logic       last;
  } tdp_item_t;

  // Queue status seen by the front end
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } tdp_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/tdp_front.sv =====
// ----------------------------------------------------------------------------
// Time delta parser front end
// Accepts text bytes, classifies each one and pushes the record to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        symbol,
  input  wire logic              last_symbol,
  input  wire tdp_pkg::tdp_qstat_t qstat,
  output logic                   push,
  output tdp_pkg::tdp_item_t     push_item
);
  import tdp_pkg::*;

  logic is_digit;
  logic is_sign;

  // Hold the source off while the queue is full
  assign in_stall = qstat.full;
  assign push     = in_valid & ~qstat.full;

  // Classify the byte
  always_comb begin
    is_digit = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
    is_sign  = (symbol == CH_MINUS) || (symbol == CH_PLUS);
    push_item.is_num  = is_digit | is_sign;
    push_item.is_sign = is_sign;
    push_item.minus   = (symbol == CH_MINUS);
    push_item.digit   = symbol[3:0];
    push_item.is_n    = (symbol == CH_N);
    push_item.last    = last_symbol;
    unique case (symbol)
      CH_Y, CH_A: push_item.suf_first = SUF_YEAR;
      CH_M:       push_item.suf_first = SUF_M;
      CH_J, CH_D: push_item.suf_first = SUF_DAY;
      CH_H:       push_item.suf_first = SUF_HOUR;
      CH_S:       push_item.suf_first = SUF_SECOND;
      default:    push_item.suf_first = SUF_BAD;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tdp_queue.sv =====
// ----------------------------------------------------------------------------
// Time delta parser queue
// Short first-in first-out buffer of classified bytes between the front end
// and the execute stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire tdp_pkg::tdp_item_t push_item,
  input  wire logic               pop,
  output tdp_pkg::tdp_item_t      head,
  output tdp_pkg::tdp_qstat_t     qstat
);
  import tdp_pkg::*;

  tdp_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign head        = entries[rd_ptr];
  assign qstat.count = count;
  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tdp_back.sv =====
// ----------------------------------------------------------------------------
// Time delta parser execute stage
// Applies one classified byte per cycle to the parse state while the queue
// holds one and no stalled result blocks a final byte, closes segments into
// unit values and registers the result of each string.
`default_nettype none

module tdp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  wire tdp_pkg::tdp_item_t it,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    ok,
  output logic signed [15:0]      years,
  output logic signed [15:0]      months,
  output logic signed [15:0]      days,
  output logic signed [15:0]      hours,
  output logic signed [15:0]      minutes,
  output logic signed [15:0]      seconds
);
  import tdp_pkg::*;

  // Parse state
  logic        in_suffix;
  logic        at_start;
  logic [15:0] magnitude;
  logic [2:0]  number_form;
  logic [3:0]  suffix_code;
  logic [15:0] unit_vals [UNIT_COUNT];
  logic        failed;

  // Next-state terms
  logic [3:0]  suf_new;
  logic [3:0]  c_suf;
  logic [2:0]  slot;
  logic        slot_ok;
  logic [15:0] unit_cur;
  logic        range_ok;
  logic        c_bad;
  logic [15:0] c_val;
  logic        do_commit;
  logic        fail_all;
  logic [15:0] mag_b;
  logic [2:0]  form_b;
  logic [18:0] prod;
  logic [15:0] magnitude_next;
  logic [2:0]  form_next;
  logic [15:0] units_next [UNIT_COUNT];
  logic        out_free;

  // Take a byte when one waits and a final byte has room to land
  assign out_free = ~out_valid | ~out_stall;
  assign pop      = ~q_empty & (~it.last | out_free);

  // Suffix letter tracking
  always_comb begin
    if (suffix_code == SUF_EMPTY) begin
      suf_new = it.suf_first;
    end else if (suffix_code == SUF_M && it.is_n) begin
      suf_new = SUF_MN;
    end else begin
      suf_new = SUF_BAD;
    end
  end

  // Segment close check
  always_comb begin
    c_suf   = it.is_num ? suffix_code : suf_new;
    slot    = 3'(c_suf - 4'd1);
    slot_ok = (c_suf != SUF_EMPTY) && (c_suf < SUF_BAD);
    unit_cur = '0;
    for (int k = 0; k < UNIT_COUNT; k++) begin
      if (slot == 3'(k)) begin
        unit_cur = unit_cur | unit_vals[k];
      end
    end
    range_ok = ((number_form == FORM_NEG) && (magnitude <= NEG_LIMIT)) ||
               ((number_form == FORM_POS) && (magnitude <= POS_LIMIT));
    c_bad    = ~slot_ok | (unit_cur != '0) | ~range_ok;
    c_val    = (number_form == FORM_NEG) ? (~magnitude + 16'd1) : magnitude;
    do_commit = (it.is_num & in_suffix) | (it.last & ~it.is_num);
    fail_all  = failed | (at_start & ~it.is_num) | (do_commit & c_bad) |
                (it.last & it.is_num);
    for (int k = 0; k < UNIT_COUNT; k++) begin
      units_next[k] = (do_commit && !c_bad && slot == 3'(k)) ? c_val : unit_vals[k];
    end
  end

  // Number accumulate on a fresh segment when a suffix just closed
  always_comb begin
    mag_b  = (in_suffix) ? '0 : magnitude;
    form_b = (in_suffix) ? FORM_NONE : number_form;
    prod   = ({3'b0, mag_b} << 3) + ({3'b0, mag_b} << 1) + 19'(it.digit);
    if (it.is_sign) begin
      magnitude_next = mag_b;
      if (form_b == FORM_NONE) begin
        form_next = it.minus ? FORM_MINUS : FORM_PLUS;
      end else begin
        form_next = FORM_BAD;
      end
    end else begin
      magnitude_next = (prod > {3'b0, MAG_CAP}) ? MAG_CAP : prod[15:0];
      if (form_b == FORM_NONE || form_b == FORM_PLUS) begin
        form_next = FORM_POS;
      end else if (form_b == FORM_MINUS) begin
        form_next = FORM_NEG;
      end else begin
        form_next = form_b;
      end
    end
  end

  // Update parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_suffix   <= 1'b0;
      at_start    <= 1'b1;
      magnitude   <= '0;
      number_form <= FORM_NONE;
      suffix_code <= SUF_EMPTY;
      failed      <= 1'b0;
      for (int k = 0; k < UNIT_COUNT; k++) begin
        unit_vals[k] <= '0;
      end
    end else if (pop) begin
      if (it.last) begin
        in_suffix   <= 1'b0;
        at_start    <= 1'b1;
        magnitude   <= '0;
        number_form <= FORM_NONE;
        suffix_code <= SUF_EMPTY;
        failed      <= 1'b0;
        for (int k = 0; k < UNIT_COUNT; k++) begin
          unit_vals[k] <= '0;
        end
      end else begin
        at_start <= 1'b0;
        failed   <= fail_all;
        for (int k = 0; k < UNIT_COUNT; k++) begin
          unit_vals[k] <= units_next[k];
        end
        if (it.is_num) begin
          in_suffix   <= 1'b0;
          suffix_code <= SUF_EMPTY;
          magnitude   <= magnitude_next;
          number_form <= form_next;
        end else begin
          in_suffix   <= 1'b1;
          suffix_code <= suf_new;
        end
      end
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && it.last) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload; zero all units on a failed string
  always_ff @(posedge clk) begin
    if (pop && it.last) begin
      ok      <= ~fail_all;
      years   <= fail_all ? '0 : units_next[0];
      months  <= fail_all ? '0 : units_next[1];
      days    <= fail_all ? '0 : units_next[2];
      hours   <= fail_all ? '0 : units_next[3];
      minutes <= fail_all ? '0 : units_next[4];
      seconds <= fail_all ? '0 : units_next[5];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/time_delta_text_parser.sv =====
// Result path: the execute stage registers the result of a string when it takes
//   the last byte of that string from the queue head, after any earlier bytes.
// Throughput: one text byte per cycle while in_stall is low; a final byte
//   waits in the two-entry queue only while the previous result is stalled.
// Reset: synchronous rst empties the queue, drops out_valid and returns the
//   parse state to the start of a string.
// ----------------------------------------------------------------------------
// Time delta text parser
// Parses signed number and unit-suffix segments of a time difference string
// into six signed 16-bit unit counts and an ok flag.
// ----------------------------------------------------------------------------
`default_nettype none

module time_delta_text_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        symbol,
  input  wire logic              last_symbol,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   ok,
  output logic signed [15:0]     years,
  output logic signed [15:0]     months,
  output logic signed [15:0]     days,
  output logic signed [15:0]     hours,
  output logic signed [15:0]     minutes,
  output logic signed [15:0]     seconds
);
  import tdp_pkg::*;

  logic       push;
  tdp_item_t  push_item;
  logic       pop;
  tdp_item_t  head;
  tdp_qstat_t qstat;

  // Classify incoming requests
  tdp_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .symbol     (symbol),
    .last_symbol(last_symbol),
    .qstat      (qstat),
    .push       (push),
    .push_item  (push_item)
  );

  // Buffer classified bytes
  tdp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // Execute parse steps and register results
  tdp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (qstat.empty),
    .it       (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ok       (ok),
    .years    (years),
    .months   (months),
    .days     (days),
    .hours    (hours),
    .minutes  (minutes),
    .seconds  (seconds)
  );

`ifndef SYNTHESIS
  // A failed string reports all units as zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (years == '0 && months == '0 && days == '0 &&
                            hours == '0 && minutes == '0 && seconds == '0))
    else $error("failed string carries nonzero units");

  // Queue fill never exceeds its depth
  assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue overfilled");

  // Execute stage never takes a byte from an empty queue
  assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // No result is presented right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
